FILE: hdl/fvmca_pkg.sv
// Shared types, constants and saturating arithmetic of the cell coefficient assembler.
package fvmca_pkg;

  localparam int unsigned ColumnWidth   = 7;
  localparam int unsigned RowWidth      = 5;
  localparam int unsigned IndexWidth    = 12;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned CondWidth     = 31;
  localparam int unsigned KindsWidth    = 4;
  localparam int unsigned NumSides      = 4;
  localparam int unsigned CfgIndexWidth = 3;

  // Side order matches the boundary kind bits.
  localparam int unsigned SideWest  = 0;
  localparam int unsigned SideEast  = 1;
  localparam int unsigned SideSouth = 2;
  localparam int unsigned SideNorth = 3;

  // East and north faces take the half flux with a minus sign.
  localparam logic [NumSides-1:0] SideNegative = 4'b1010;

  localparam logic [DataWidth-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [DataWidth-1:0] SatMin = 32'h8000_0000;

  localparam logic [KindsWidth-1:0] KindsReset     = 4'd14;
  localparam logic [DataWidth-1:0]  WestValueReset = 32'd1310720;

  typedef enum logic [CfgIndexWidth-1:0] {
    RegBoundaryKinds = 3'd0,
    RegWestValue     = 3'd1,
    RegEastValue     = 3'd2,
    RegSouthValue    = 3'd3,
    RegNorthValue    = 3'd4,
    RegConductanceX  = 3'd5,
    RegConductanceY  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ColumnWidth-1:0]     column;
    logic [RowWidth-1:0]        row;
    logic signed [DataWidth-1:0] flux_x_here;
    logic signed [DataWidth-1:0] flux_x_west;
    logic signed [DataWidth-1:0] flux_x_east;
    logic signed [DataWidth-1:0] flux_y_here;
    logic signed [DataWidth-1:0] flux_y_south;
    logic signed [DataWidth-1:0] flux_y_north;
  } in_t;

  typedef struct packed {
    logic [IndexWidth-1:0]       cell_index;
    logic signed [DataWidth-1:0] coef_west;
    logic signed [DataWidth-1:0] coef_east;
    logic signed [DataWidth-1:0] coef_south;
    logic signed [DataWidth-1:0] coef_north;
    logic signed [DataWidth-1:0] coef_diagonal;
    logic signed [DataWidth-1:0] source_term;
  } out_t;

  // Clamp a two's complement value with two guard bits to 32 bits.
  function automatic logic [DataWidth-1:0] sat32(input logic [DataWidth+1:0] v);
    logic [DataWidth-1:0] r;
    if (v[DataWidth+1:DataWidth-1] == 3'b000 || v[DataWidth+1:DataWidth-1] == 3'b111) begin
      r = v[DataWidth-1:0];
    end else if (v[DataWidth+1]) begin
      r = SatMin;
    end else begin
      r = SatMax;
    end
    return r;
  endfunction

  function automatic logic [DataWidth-1:0] add_sat(input logic [DataWidth-1:0] a,
                                                   input logic [DataWidth-1:0] b);
    logic [DataWidth+1:0] s;
    s = {{2{a[DataWidth-1]}}, a} + {{2{b[DataWidth-1]}}, b};
    return sat32(s);
  endfunction

  function automatic logic [DataWidth-1:0] sub_sat(input logic [DataWidth-1:0] a,
                                                   input logic [DataWidth-1:0] b);
    logic [DataWidth+1:0] s;
    s = {{2{a[DataWidth-1]}}, a} - {{2{b[DataWidth-1]}}, b};
    return sat32(s);
  endfunction

  // Q16.16 product: floor shift by 16, then clamp.
  function automatic logic [DataWidth-1:0] sat_prod(input logic [2*DataWidth-1:0] p);
    logic [DataWidth-1:0] r;
    if ((&p[63:47]) || !(|p[63:47])) begin
      r = p[47:16];
    end else if (p[63]) begin
      r = SatMin;
    end else begin
      r = SatMax;
    end
    return r;
  endfunction

endpackage

FILE: hdl/fvm_cell_coefficient_assembler_top.sv
// Top level of the finite-volume cell coefficient assembler pipeline.
// Order: input register, work stages, result register; the result and its valid
//   are driven straight from the result register.
// Throughput: one cell per cycle; seven register stages each hold one cell, and a
//   stall on the output backs up only the stages that are full.
// Reset: asynchronous; clears the stage valid bits, loads configuration reset values.
module fvm_cell_coefficient_assembler_top import fvmca_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = 128,
  parameter int unsigned GRID_ROWS    = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_t                      in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_t                     out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [DataWidth-1:0]     cfg_data_i
);

  localparam int unsigned LastColumn = GRID_COLUMNS - 1;
  localparam int unsigned LastRow    = GRID_ROWS - 1;
  localparam int unsigned NumStages  = 6;  // input register plus five work stages

  // Per-cell working set carried down the pipe; side index 0..3 = W, E, S, N.
  typedef struct packed {
    logic [NumSides-1:0]                 at_edge;
    logic [IndexWidth-1:0]               cell_index;
    logic [NumSides-1:0][DataWidth-1:0]  flux;   // face mass flux
    logic [NumSides-1:0][DataWidth-1:0]  coef;   // neighbor coefficient A
    logic [NumSides-1:0][DataWidth-1:0]  sink;   // Dirichlet term 2D +/- F
    logic [NumSides-1:0][2*DataWidth-1:0] prod;  // sink times boundary value
    logic [NumSides-1:0][DataWidth-1:0]  term;   // source contribution per side
    logic [DataWidth-1:0]                sp;
    logic [DataWidth-1:0]                su;
    logic [DataWidth-1:0]                ap;
  } stage_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KindsWidth-1:0]              kinds_q;
  logic [NumSides-1:0][DataWidth-1:0] value_q;
  logic [CondWidth-1:0]               cond_x_q;
  logic [CondWidth-1:0]               cond_y_q;
  logic [NumSides-1:0][CondWidth-1:0] cond_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q            <= KindsReset;
      value_q[SideWest]  <= WestValueReset;
      value_q[SideEast]  <= '0;
      value_q[SideSouth] <= '0;
      value_q[SideNorth] <= '0;
      cond_x_q           <= '0;
      cond_y_q           <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegBoundaryKinds: kinds_q            <= cfg_data_i[KindsWidth-1:0];
        RegWestValue:     value_q[SideWest]  <= cfg_data_i;
        RegEastValue:     value_q[SideEast]  <= cfg_data_i;
        RegSouthValue:    value_q[SideSouth] <= cfg_data_i;
        RegNorthValue:    value_q[SideNorth] <= cfg_data_i;
        RegConductanceX:  cond_x_q           <= cfg_data_i[CondWidth-1:0];
        RegConductanceY:  cond_y_q           <= cfg_data_i[CondWidth-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cond_side = {cond_y_q, cond_y_q, cond_x_q, cond_x_q};

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage advances when it is empty or the next one
  // advances, so bubbles collapse and input keeps flowing while a result waits.
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;     // bit 0: input register, bits 1..5: work stages
  logic                 out_vld_q;
  logic [NumStages:0]   adv;

  always_comb begin
    adv[NumStages] = !out_vld_q || out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (adv[NumStages]) begin
        out_vld_q <= vld_q[NumStages-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: edge detection, matrix row index, face fluxes.
  // Interior faces average the two cell fluxes with floor; edges use own flux.
  // ---------------------------------------------------------------------------
  in_t                                in_q;
  stage_t                             stg1_d, stg1_q;
  logic [NumSides-1:0][DataWidth-1:0] own_flux;
  logic [NumSides-1:0][DataWidth-1:0] nbr_flux;
  logic [DataWidth:0]                 flux_sum [NumSides];
  logic [31:0]                        idx_wide;

  assign own_flux = {in_q.flux_y_here, in_q.flux_y_here, in_q.flux_x_here, in_q.flux_x_here};
  assign nbr_flux = {in_q.flux_y_north, in_q.flux_y_south, in_q.flux_x_east, in_q.flux_x_west};
  assign idx_wide = 32'(in_q.column) * 32'(GRID_ROWS) + 32'(in_q.row);

  always_comb begin
    stg1_d                    = '0;
    stg1_d.at_edge[SideWest]  = (in_q.column == '0);
    stg1_d.at_edge[SideEast]  = (32'(in_q.column) >= 32'(LastColumn));
    stg1_d.at_edge[SideSouth] = (in_q.row == '0);
    stg1_d.at_edge[SideNorth] = (32'(in_q.row) >= 32'(LastRow));
    stg1_d.cell_index         = idx_wide[IndexWidth-1:0];
    for (int i = 0; i < NumSides; i++) begin
      flux_sum[i] = {own_flux[i][DataWidth-1], own_flux[i]}
                  + {nbr_flux[i][DataWidth-1], nbr_flux[i]};
      stg1_d.flux[i] = stg1_d.at_edge[i] ? own_flux[i] : flux_sum[i][DataWidth:1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: neighbor coefficients D +/- F/2 and Dirichlet terms 2D +/- F.
  // ---------------------------------------------------------------------------
  stage_t                             stg2_d, stg2_q;
  logic [NumSides-1:0][DataWidth-1:0] cond_wide;
  logic [NumSides-1:0][DataWidth-1:0] cond_dbl;
  logic [NumSides-1:0][DataWidth-1:0] half_flux;

  always_comb begin
    stg2_d = stg1_q;
    for (int i = 0; i < NumSides; i++) begin
      cond_wide[i] = {1'b0, cond_side[i]};
      cond_dbl[i]  = cond_side[i][CondWidth-1] ? SatMax : {cond_side[i][CondWidth-2:0], 1'b0};
      half_flux[i] = {stg1_q.flux[i][DataWidth-1], stg1_q.flux[i][DataWidth-1:1]};
      if (SideNegative[i]) begin
        stg2_d.coef[i] = sub_sat(cond_wide[i], half_flux[i]);
        stg2_d.sink[i] = sub_sat(cond_dbl[i], stg1_q.flux[i]);
      end else begin
        stg2_d.coef[i] = add_sat(cond_wide[i], half_flux[i]);
        stg2_d.sink[i] = add_sat(cond_dbl[i], stg1_q.flux[i]);
      end
      // Zero the coefficient on a domain edge.
      if (stg1_q.at_edge[i]) begin
        stg2_d.coef[i] = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: boundary products; sink chain west, east; diagonal Aw + Ae + As.
  // ---------------------------------------------------------------------------
  stage_t                             stg3_d, stg3_q;
  logic [NumSides-1:0][DataWidth-1:0] sp_term3;
  logic [DataWidth-1:0]               sp_mid3;
  logic [DataWidth-1:0]               ap_mid3;
  logic signed [DataWidth-1:0]        mul_a [NumSides];
  logic signed [DataWidth-1:0]        mul_b [NumSides];
  logic signed [2*DataWidth-1:0]      mul_p [NumSides];

  always_comb begin
    stg3_d = stg2_q;
    for (int i = 0; i < NumSides; i++) begin
      // Signed 32 x 32 product, both operands sign-extended to the full width.
      mul_a[i]       = stg2_q.sink[i];
      mul_b[i]       = value_q[i];
      mul_p[i]       = mul_a[i] * mul_b[i];
      stg3_d.prod[i] = mul_p[i];
      sp_term3[i]    = (stg2_q.at_edge[i] && !kinds_q[i]) ? stg2_q.sink[i] : '0;
    end
    sp_mid3   = sub_sat('0, sp_term3[SideWest]);
    stg3_d.sp = sub_sat(sp_mid3, sp_term3[SideEast]);
    ap_mid3   = add_sat(stg2_q.coef[SideWest], stg2_q.coef[SideEast]);
    stg3_d.ap = add_sat(ap_mid3, stg2_q.coef[SideSouth]);
  end

  // ---------------------------------------------------------------------------
  // Stage 4: per-side source terms; sink chain south, north; diagonal + An + Fe.
  // ---------------------------------------------------------------------------
  stage_t                             stg4_d, stg4_q;
  logic [NumSides-1:0][DataWidth-1:0] sp_term4;
  logic [DataWidth-1:0]               sp_mid4;
  logic [DataWidth-1:0]               ap_mid4;

  always_comb begin
    stg4_d = stg3_q;
    for (int i = 0; i < NumSides; i++) begin
      sp_term4[i] = (stg3_q.at_edge[i] && !kinds_q[i]) ? stg3_q.sink[i] : '0;
      if (!stg3_q.at_edge[i]) begin
        stg4_d.term[i] = '0;
      end else if (kinds_q[i]) begin
        stg4_d.term[i] = value_q[i];  // Neumann: flux already area-scaled
      end else begin
        stg4_d.term[i] = sat_prod(stg3_q.prod[i]);
      end
    end
    sp_mid4   = sub_sat(stg3_q.sp, sp_term4[SideSouth]);
    stg4_d.sp = sub_sat(sp_mid4, sp_term4[SideNorth]);
    ap_mid4   = add_sat(stg3_q.ap, stg3_q.coef[SideNorth]);
    stg4_d.ap = add_sat(ap_mid4, stg3_q.flux[SideEast]);
  end

  // ---------------------------------------------------------------------------
  // Stage 5: source chain west, east, south; diagonal - Fw + Fn.
  // ---------------------------------------------------------------------------
  stage_t               stg5_d, stg5_q;
  logic [DataWidth-1:0] su_mid5;
  logic [DataWidth-1:0] ap_mid5;

  always_comb begin
    stg5_d    = stg4_q;
    su_mid5   = add_sat(stg4_q.term[SideWest], stg4_q.term[SideEast]);
    stg5_d.su = add_sat(su_mid5, stg4_q.term[SideSouth]);
    ap_mid5   = sub_sat(stg4_q.ap, stg4_q.flux[SideWest]);
    stg5_d.ap = add_sat(ap_mid5, stg4_q.flux[SideNorth]);
  end

  // ---------------------------------------------------------------------------
  // Result stage: source + north; diagonal - Fs - Sp; negate off-diagonals.
  // ---------------------------------------------------------------------------
  out_t                 out_d, out_q;
  logic [DataWidth-1:0] ap_mid6;

  always_comb begin
    ap_mid6              = sub_sat(stg5_q.ap, stg5_q.flux[SideSouth]);
    out_d.cell_index     = stg5_q.cell_index;
    out_d.coef_west      = sub_sat('0, stg5_q.coef[SideWest]);
    out_d.coef_east      = sub_sat('0, stg5_q.coef[SideEast]);
    out_d.coef_south     = sub_sat('0, stg5_q.coef[SideSouth]);
    out_d.coef_north     = sub_sat('0, stg5_q.coef[SideNorth]);
    out_d.coef_diagonal  = sub_sat(ap_mid6, stg5_q.sp);
    out_d.source_term    = add_sat(stg5_q.su, stg5_q.term[SideNorth]);
  end

  // Payload registers: load only when the stage advances and its feeder holds a cell.
  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv[1] && vld_q[0]) begin
      stg1_q <= stg1_d;
    end
    if (adv[2] && vld_q[1]) begin
      stg2_q <= stg2_d;
    end
    if (adv[3] && vld_q[2]) begin
      stg3_q <= stg3_d;
    end
    if (adv[4] && vld_q[3]) begin
      stg4_q <= stg4_d;
    end
    if (adv[5] && vld_q[4]) begin
      stg5_q <= stg5_d;
    end
    if (adv[6] && vld_q[5]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/fvmca_checker.sv
// Port-level assertions for the cell coefficient assembler, bound to its top level.
module fvmca_checker import fvmca_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  localparam int unsigned Latency = 7;

  // Track transfers that met an open output path on every following edge.
  logic [Latency-1:0] flow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q <= '0;
    end else if (out_ready_i) begin
      flow_q <= {flow_q[Latency-2:0], in_valid_i && in_ready_o};
    end else begin
      flow_q <= '0;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item changed or dropped while stalled");

  a_ready_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled although the output side is free");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flow_q[Latency-1] |-> out_valid_o)
    else $error("no result after the pipeline latency with output open");

endmodule

bind fvm_cell_coefficient_assembler_top fvmca_checker u_fvmca_checker (.*);

FILE: sim/fvm_cell_coefficient_assembler_checker.sv
// Row checker for the cell coefficient assembler: models every cell transfer and compares rows.
module fvm_cell_coefficient_assembler_checker import fvmca_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = 128,
  parameter int unsigned GRID_ROWS    = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  in_t                      in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  out_t                     out_data_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [DataWidth-1:0]     cfg_data_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMax = 64'sh7FFF_FFFF;
  localparam longint QMin = -64'sh8000_0000;
  localparam int unsigned ReportLimit = 10;

  logic [KindsWidth-1:0] kinds_q;
  longint                side_value_q [NumSides];
  longint                cond_x_q;
  longint                cond_y_q;

  out_t        rows_awaited [$];
  out_t        want;
  int unsigned failures = 0;
  int unsigned reports  = 0;
  int unsigned awaited  = 0;

  assign fail_count_o = failures;
  assign pending_o    = awaited;

  function automatic longint clamp_q(input longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  // One matrix row from the cell and the current register copy.
  function automatic out_t assemble_row(input in_t c);
    longint      face_flux [NumSides];
    longint      coef [NumSides];
    logic        on_edge [NumSides];
    longint      own;
    longint      cond;
    longint      half;
    longint      t;
    longint      sink;
    longint      rhs;
    longint      diag;
    int unsigned idx;
    out_t        r;
    on_edge[SideWest]  = (c.column == 0);
    on_edge[SideEast]  = (c.column >= GRID_COLUMNS - 1);
    on_edge[SideSouth] = (c.row == 0);
    on_edge[SideNorth] = (c.row >= GRID_ROWS - 1);

    own = $signed(c.flux_x_here);
    face_flux[SideWest] = on_edge[SideWest] ? own : (own + $signed(c.flux_x_west)) >>> 1;
    face_flux[SideEast] = on_edge[SideEast] ? own : (own + $signed(c.flux_x_east)) >>> 1;
    own = $signed(c.flux_y_here);
    face_flux[SideSouth] = on_edge[SideSouth] ? own : (own + $signed(c.flux_y_south)) >>> 1;
    face_flux[SideNorth] = on_edge[SideNorth] ? own : (own + $signed(c.flux_y_north)) >>> 1;

    sink = 0;
    rhs  = 0;
    for (int s = 0; s < NumSides; s++) begin
      cond = (s == SideWest || s == SideEast) ? cond_x_q : cond_y_q;
      half = face_flux[s] >>> 1;
      coef[s] = clamp_q(SideNegative[s] ? cond - half : cond + half);
      if (on_edge[s]) begin
        coef[s] = 0;
        if (kinds_q[s]) begin
          rhs = clamp_q(rhs + side_value_q[s]);
        end else begin
          t = clamp_q(clamp_q(2 * cond) + (SideNegative[s] ? -face_flux[s] : face_flux[s]));
          sink = clamp_q(sink - t);
          rhs  = clamp_q(rhs + clamp_q((t * side_value_q[s]) >>> 16));
        end
      end
    end

    diag = clamp_q(coef[SideWest] + coef[SideEast]);
    diag = clamp_q(diag + coef[SideSouth]);
    diag = clamp_q(diag + coef[SideNorth]);
    diag = clamp_q(diag + face_flux[SideEast]);
    diag = clamp_q(diag - face_flux[SideWest]);
    diag = clamp_q(diag + face_flux[SideNorth]);
    diag = clamp_q(diag - face_flux[SideSouth]);
    diag = clamp_q(diag - sink);

    idx = c.column * GRID_ROWS + c.row;
    r.cell_index    = idx[IndexWidth-1:0];
    r.coef_west     = DataWidth'(clamp_q(-coef[SideWest]));
    r.coef_east     = DataWidth'(clamp_q(-coef[SideEast]));
    r.coef_south    = DataWidth'(clamp_q(-coef[SideSouth]));
    r.coef_north    = DataWidth'(clamp_q(-coef[SideNorth]));
    r.coef_diagonal = DataWidth'(diag);
    r.source_term   = DataWidth'(rhs);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DataWidth-1:0] exp_v,
                             input logic [DataWidth-1:0] got_v);
    if (got_v !== exp_v) begin
      failures++;
      if (reports < ReportLimit) begin
        $display("row %0d field %s: expected %h, got %h", exp_v === got_v ? 0 : want.cell_index,
                 name, exp_v, got_v);
      end
      reports++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q                  = KindsReset;
      side_value_q[SideWest]   = longint'($signed(WestValueReset));
      side_value_q[SideEast]   = 0;
      side_value_q[SideSouth]  = 0;
      side_value_q[SideNorth]  = 0;
      cond_x_q                 = 0;
      cond_y_q                 = 0;
      rows_awaited.delete();
      awaited                  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegBoundaryKinds: kinds_q                 = cfg_data_i[KindsWidth-1:0];
          RegWestValue:     side_value_q[SideWest]  = longint'($signed(cfg_data_i));
          RegEastValue:     side_value_q[SideEast]  = longint'($signed(cfg_data_i));
          RegSouthValue:    side_value_q[SideSouth] = longint'($signed(cfg_data_i));
          RegNorthValue:    side_value_q[SideNorth] = longint'($signed(cfg_data_i));
          RegConductanceX:  cond_x_q                = longint'(cfg_data_i[CondWidth-1:0]);
          RegConductanceY:  cond_y_q                = longint'(cfg_data_i[CondWidth-1:0]);
          default: ;
        endcase
      end

      // Retire the oldest row before queueing a new cell from the same edge.
      if (out_valid_i && out_ready_i) begin
        if (rows_awaited.size() == 0) begin
          failures++;
          if (reports < ReportLimit) begin
            $display("row %0d transferred with no cell waiting", out_data_i.cell_index);
          end
          reports++;
        end else begin
          want = rows_awaited.pop_front();
          check_field("cell_index", DataWidth'(want.cell_index),
                      DataWidth'(out_data_i.cell_index));
          check_field("coef_west", want.coef_west, out_data_i.coef_west);
          check_field("coef_east", want.coef_east, out_data_i.coef_east);
          check_field("coef_south", want.coef_south, out_data_i.coef_south);
          check_field("coef_north", want.coef_north, out_data_i.coef_north);
          check_field("coef_diagonal", want.coef_diagonal, out_data_i.coef_diagonal);
          check_field("source_term", want.source_term, out_data_i.source_term);
        end
      end

      if (in_valid_i && in_ready_i) begin
        rows_awaited.push_back(assemble_row(in_data_i));
      end
      awaited = rows_awaited.size();
    end
  end

endmodule

FILE: sim/fvm_cell_coefficient_assembler_top_tb.sv
// Testbench top of the cell coefficient assembler: drives cells and registers, gives the verdict.
module fvm_cell_coefficient_assembler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fvmca_pkg::*;

  localparam int unsigned GridColumns   = 128;
  localparam int unsigned GridRows      = 32;
  localparam int unsigned RandomPhases  = 10;
  localparam int unsigned CellsPerPhase = 185;
  // Pipeline is seven stages deep; watch a little longer for stray rows.
  localparam int unsigned DrainCycles   = 10;
  localparam logic [DataWidth-1:0] CondMax = 32'h7FFF_FFFF;
  localparam logic [DataWidth-1:0] QOne    = 32'h0001_0000;
  localparam logic [DataWidth-1:0] QMinus1 = 32'hFFFF_FFFF;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_t                      in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_data;
  logic                     cfg_we    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [DataWidth-1:0]     cfg_data  = '0;

  int unsigned failures;
  int unsigned awaited;
  // Set for phases that send cells back to back with no gaps.
  bit          steady = 1'b0;

  always #6 clk = ~clk;

  fvm_cell_coefficient_assembler_top #(
    .GRID_COLUMNS(GridColumns),
    .GRID_ROWS   (GridRows)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  fvm_cell_coefficient_assembler_checker #(
    .GRID_COLUMNS(GridColumns),
    .GRID_ROWS   (GridRows)
  ) row_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(failures),
    .pending_o   (awaited)
  );

  // Q16.16 value: the extremes, -2^-16 and 0, small magnitudes so that results stay
  // mostly unsaturated, and full-range words so every bit toggles.
  function automatic logic [DataWidth-1:0] pick_value();
    logic [DataWidth-1:0] mag;
    mag = $urandom_range(0, 1 << 22);
    case ($urandom_range(0, 9))
      0:       return SatMax;
      1:       return SatMin;
      2:       return '0;
      3:       return QMinus1;
      4, 5, 6: return $urandom_range(0, 1) ? -mag : mag;
      default: return $urandom();
    endcase
  endfunction

  // Conductance word; bit 31 is set now and then to exercise the register mask.
  function automatic logic [DataWidth-1:0] pick_conductance();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return CondMax;
      2:          return 32'hFFFF_FFFF;
      3, 4, 5, 6: return $urandom_range(0, 1 << 21);
      default:    return $urandom();
    endcase
  endfunction

  // Favor the edges and the cells right next to them.
  function automatic int unsigned pick_position(input int unsigned last);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return last;
      2:       return last - 1;
      3:       return 1;
      default: return $urandom_range(0, last);
    endcase
  endfunction

  function automatic in_t make_cell(input int unsigned col, input int unsigned row,
                                    input logic [DataWidth-1:0] fxh,
                                    input logic [DataWidth-1:0] fxw,
                                    input logic [DataWidth-1:0] fxe,
                                    input logic [DataWidth-1:0] fyh,
                                    input logic [DataWidth-1:0] fys,
                                    input logic [DataWidth-1:0] fyn);
    in_t c;
    c.column       = col[ColumnWidth-1:0];
    c.row          = row[RowWidth-1:0];
    c.flux_x_here  = fxh;
    c.flux_x_west  = fxw;
    c.flux_x_east  = fxe;
    c.flux_y_here  = fyh;
    c.flux_y_south = fys;
    c.flux_y_north = fyn;
    return c;
  endfunction

  function automatic in_t random_cell();
    return make_cell(pick_position(GridColumns - 1), pick_position(GridRows - 1),
                     pick_value(), pick_value(), pick_value(),
                     pick_value(), pick_value(), pick_value());
  endfunction

  // Sender gap: mostly none, sometimes a short one, rarely a long pause.
  function automatic int unsigned pick_gap();
    if (steady) return 0;
    case ($urandom_range(0, 19))
      13, 14, 15, 16, 17, 18: return $urandom_range(1, 3);
      19:                     return $urandom_range(8, 40);
      default:                return 0;
    endcase
  endfunction

  // Offer one cell and hold it until the transfer. Valid is dropped only when a gap
  // is taken, so it never falls and rises within one step.
  task automatic send_cell(input in_t c);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every row of the phase has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DataWidth-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [DataWidth-1:0] kinds,
                           input logic [DataWidth-1:0] west_v,
                           input logic [DataWidth-1:0] east_v,
                           input logic [DataWidth-1:0] south_v,
                           input logic [DataWidth-1:0] north_v,
                           input logic [DataWidth-1:0] cond_x,
                           input logic [DataWidth-1:0] cond_y);
    write_reg(RegBoundaryKinds, kinds);
    write_reg(RegWestValue, west_v);
    write_reg(RegEastValue, east_v);
    write_reg(RegSouthValue, south_v);
    write_reg(RegNorthValue, north_v);
    write_reg(RegConductanceX, cond_x);
    write_reg(RegConductanceY, cond_y);
  endtask

  // Receiver: bursts of ready, short stalls, a few long stalls and long open stretches.
  initial begin
    int unsigned len;
    int unsigned pick;
    logic        level;
    forever begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        level = 1'b1;
        len   = $urandom_range(1, 16);
      end else if (pick < 17) begin
        level = 1'b0;
        len   = $urandom_range(1, 3);
      end else if (pick < 19) begin
        level = 1'b0;
        len   = $urandom_range(8, 40);
      end else begin
        level = 1'b1;
        len   = $urandom_range(50, 200);
      end
      @(negedge clk);
      out_ready <= level;
      repeat (len - 1) @(negedge clk);
    end
  end

  initial begin
    in_t directed [$];
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed cells under the reset registers: corners, flux extremes, interior
    // averaging with odd and negative sums, and neighbor fluxes that an edge ignores.
    directed.push_back(make_cell(0, 0, '0, '0, '0, '0, '0, '0));
    directed.push_back(make_cell(0, 0, SatMax, SatMax, SatMax, SatMax, SatMax, SatMax));
    directed.push_back(make_cell(0, 0, SatMin, SatMin, SatMin, SatMin, SatMin, SatMin));
    directed.push_back(make_cell(127, 31, SatMax, SatMax, SatMax, SatMax, SatMax, SatMax));
    directed.push_back(make_cell(127, 31, SatMin, SatMin, SatMin, SatMin, SatMin, SatMin));
    directed.push_back(make_cell(0, 31, SatMax, SatMin, SatMax, SatMin, SatMax, SatMin));
    directed.push_back(make_cell(127, 0, SatMin, SatMax, SatMin, SatMax, SatMin, SatMax));
    directed.push_back(make_cell(1, 1, '0, '0, '0, '0, '0, '0));
    directed.push_back(make_cell(1, 1, SatMax, SatMax, SatMax, SatMax, SatMax, SatMax));
    directed.push_back(make_cell(1, 1, SatMin, SatMin, SatMin, SatMin, SatMin, SatMin));
    directed.push_back(make_cell(126, 30, SatMax, SatMin, SatMin, SatMax, SatMin, SatMin));
    directed.push_back(make_cell(5, 5, QMinus1, '0, '0, QMinus1, '0, '0));
    directed.push_back(make_cell(5, 5, 32'd1, '0, '0, 32'd1, '0, '0));
    directed.push_back(make_cell(0, 5, QOne, SatMax, QOne, QOne, QOne, QOne));
    directed.push_back(make_cell(127, 5, QOne, QOne, SatMin, QOne, QOne, QOne));
    directed.push_back(make_cell(5, 0, QOne, QOne, QOne, QOne, SatMax, QOne));
    directed.push_back(make_cell(5, 31, QOne, QOne, QOne, QOne, QOne, SatMin));
    directed.push_back(make_cell(0, 0, QOne, QOne, QOne, -QOne, -QOne, -QOne));
    directed.push_back(make_cell(127, 31, -QOne, QOne, QOne, QOne, QOne, QOne));
    directed.push_back(random_cell());
    directed.push_back(random_cell());
    foreach (directed[i]) send_cell(directed[i]);
    drain();

    // Random phases; registers change only once the pipeline has emptied.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       configure('0, SatMax, SatMax, SatMax, SatMax, CondMax, CondMax);
        1:       configure(32'hF, SatMin, SatMin, SatMin, SatMin, '0, '0);
        default: configure($urandom(), pick_value(), pick_value(), pick_value(),
                           pick_value(), pick_conductance(), pick_conductance());
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (CellsPerPhase) send_cell(random_cell());
      drain();
    end

    // Watch for rows that nobody asked for.
    repeat (DrainCycles) @(negedge clk);
    if (failures == 0 && awaited == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/fvmca_pkg.sv
hdl/fvm_cell_coefficient_assembler_top.sv
hdl/fvmca_checker.sv
sim/fvm_cell_coefficient_assembler_checker.sv
sim/fvm_cell_coefficient_assembler_top_tb.sv
